### rtl/tac_pkg.sv
// Shared types, constants and the yaw lookup table for the target approach controller.
// Used by every other file of the block; depends on nothing.
package tac_pkg;

  // Counter limits.
  localparam logic [3:0] LOST_LIMIT  = 4'd8;
  localparam logic [2:0] STABLE_NEED = 3'd5;
  localparam logic [2:0] STABLE_SAT  = 3'd7;
  localparam logic [8:0] BLIND_LIMIT = 9'd300;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_RANGE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_COLUMN = 4'd1;
  localparam logic [14:0] GOAL_RANGE_RST    = 15'd256;
  localparam logic [11:0] CENTRE_COLUMN_RST = 12'd320;

  // Command shaping constants.
  localparam logic [11:0] YAW_DEADBAND  = 12'd15;
  localparam logic [10:0] YAW_MAX       = 11'd1229;
  localparam logic [11:0] TURN_FIRST    = 12'd60;
  localparam logic [12:0] BLIND_SURGE   = 13'd2048;
  localparam logic [12:0] SURGE_MIN     = 13'd512;
  localparam logic [12:0] SURGE_MAX     = 13'd5120;
  localparam logic signed [16:0] SURGE_MIN_ERR = 17'sd64;
  localparam logic signed [16:0] SURGE_MAX_ERR = 17'sd640;

  // Yaw gain 0.0035 in Q12 is 14336 / 1000 per pixel.
  localparam int YAW_NUM   = 14336;
  localparam int YAW_DEN   = 1000;
  localparam int YAW_TAB_N = 128;
  localparam int YAW_IDX_W = $clog2(YAW_TAB_N);

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_FAILURE = 2'd2,
    ST_HALTED  = 2'd3
  } status_e;

  typedef logic [10:0] yaw_mag_t;
  typedef yaw_mag_t yaw_tab_t [YAW_TAB_N];

  typedef struct packed {
    logic               mode;
    logic               seen;
    logic [11:0]        column;
    logic signed [15:0] range_q8;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic signed [11:0] yaw_q12;
    logic [12:0]        surge_q8;
  } result_t;

  // Rounded and saturated yaw magnitude for each pixel error below the table size.
  function automatic yaw_tab_t build_yaw_tab();
    yaw_tab_t t;
    int       v;
    for (int m = 0; m < YAW_TAB_N; m++) begin
      v = (m * YAW_NUM + YAW_DEN / 2) / YAW_DEN;
      if (v > int'(YAW_MAX)) v = int'(YAW_MAX);
      t[m] = yaw_mag_t'(v);
    end
    return t;
  endfunction

  localparam yaw_tab_t YAW_TAB = build_yaw_tab();

endpackage

### rtl/tac_intf.sv
// Handshake channel interfaces of the target approach controller: input word,
// result word and configuration write. Depends on tac_pkg for the widths.
interface tac_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               seen;
  logic [11:0]        column;
  logic signed [15:0] range_q8;

  modport source (output valid, output mode, output seen, output column, output range_q8,
                  input ready);
  modport sink   (input valid, input mode, input seen, input column, input range_q8,
                  output ready);
endinterface

interface tac_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [11:0] yaw_q12;
  logic [12:0]        surge_q8;

  modport source (output valid, output status, output yaw_q12, output surge_q8,
                  input ready);
  modport sink   (input valid, input status, input yaw_q12, input surge_q8,
                  output ready);
endinterface

interface tac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tac_pkg::CFG_IDX_W-1:0]  index;
  logic [tac_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tac_yaw.sv
// Yaw command from the column error: deadband, table gain with rounding, clamp.
// Depends on tac_pkg for the yaw table and limits.
module tac_yaw (
  input  logic signed [12:0] err_i,
  output logic [11:0]        mag_o,
  output logic signed [11:0] yaw_o
);

  logic [12:0] abs_err;
  logic [10:0] yaw_mag;

  assign abs_err = err_i[12] ? 13'(-err_i) : 13'(err_i);
  assign mag_o   = abs_err[11:0];

  always_comb begin
    if (mag_o < tac_pkg::YAW_DEADBAND) begin
      yaw_mag = '0;
    end else if (mag_o >= 12'(tac_pkg::YAW_TAB_N)) begin
      yaw_mag = tac_pkg::YAW_MAX;
    end else begin
      yaw_mag = tac_pkg::YAW_TAB[mag_o[tac_pkg::YAW_IDX_W-1:0]];
    end
  end

  // The command steers against the error.
  assign yaw_o = (!err_i[12] && (err_i != '0)) ? -$signed({1'b0, yaw_mag})
                                               : $signed({1'b0, yaw_mag});

endmodule

### rtl/tac_core.sv
// Tick decision logic and the lost, stable and blind counters.
// Depends on tac_pkg and instantiates tac_yaw.
module tac_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  tac_pkg::item_t   item_i,
  input  logic [14:0]      goal_range_i,
  input  logic [11:0]      centre_column_i,
  output tac_pkg::result_t result_o
);

  logic [3:0] lost_q, lost_d, lost_inc;
  logic [2:0] stable_q, stable_d, stable_inc;
  logic [8:0] blind_q, blind_d, blind_inc;

  logic signed [12:0] err;
  logic [11:0]        mag;
  logic signed [11:0] yaw;
  logic signed [16:0] range_x;
  logic signed [16:0] goal_x;
  logic signed [16:0] derr;
  logic               in_goal;
  logic [12:0]        range_surge;

  assign err     = $signed({1'b0, centre_column_i}) - $signed({1'b0, item_i.column});
  assign range_x = 17'(item_i.range_q8);
  assign goal_x  = $signed({2'b00, goal_range_i});
  assign derr    = range_x - goal_x;
  assign in_goal = (range_x > 17'sd0) && (range_x < goal_x);

  assign lost_inc   = lost_q + 4'd1;
  assign blind_inc  = blind_q + 9'd1;
  assign stable_inc = (stable_q < tac_pkg::STABLE_SAT) ? stable_q + 3'd1 : stable_q;

  tac_yaw u_yaw (
    .err_i (err),
    .mag_o (mag),
    .yaw_o (yaw)
  );

  always_comb begin
    if (derr >= tac_pkg::SURGE_MAX_ERR) begin
      range_surge = tac_pkg::SURGE_MAX;
    end else if (derr < tac_pkg::SURGE_MIN_ERR) begin
      range_surge = tac_pkg::SURGE_MIN;
    end else begin
      range_surge = {derr[9:0], 3'b000};
    end
  end

  always_comb begin
    lost_d   = lost_q;
    stable_d = stable_q;
    blind_d  = blind_q;
    result_o = '{status: tac_pkg::ST_RUNNING, yaw_q12: '0, surge_q8: '0};
    if (item_i.mode) begin
      lost_d          = '0;
      stable_d        = '0;
      blind_d         = '0;
      result_o.status = tac_pkg::ST_HALTED;
    end else if (!item_i.seen) begin
      if (lost_inc > tac_pkg::LOST_LIMIT) begin
        lost_d          = '0;
        stable_d        = '0;
        blind_d         = '0;
        result_o.status = tac_pkg::ST_FAILURE;
      end else begin
        lost_d = lost_inc;
      end
    end else begin
      lost_d   = '0;
      stable_d = in_goal ? stable_inc : '0;
      if (in_goal && (stable_inc >= tac_pkg::STABLE_NEED)) begin
        result_o.status = tac_pkg::ST_SUCCESS;
      end else if (range_x <= 17'sd0) begin
        if (blind_inc > tac_pkg::BLIND_LIMIT) begin
          blind_d         = '0;
          stable_d        = '0;
          result_o.status = tac_pkg::ST_FAILURE;
        end else begin
          blind_d           = blind_inc;
          result_o.yaw_q12  = yaw;
          result_o.surge_q8 = (mag > tac_pkg::TURN_FIRST) ? '0 : tac_pkg::BLIND_SURGE;
        end
      end else begin
        blind_d          = '0;
        result_o.yaw_q12 = yaw;
        if ((derr > 17'sd0) && (mag <= tac_pkg::TURN_FIRST)) begin
          result_o.surge_q8 = range_surge;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_q   <= '0;
      stable_q <= '0;
      blind_q  <= '0;
    end else if (adv_i) begin
      lost_q   <= lost_d;
      stable_q <= stable_d;
      blind_q  <= blind_d;
    end
  end

endmodule

### rtl/target_approach_controller_top.sv
// Top level of the target approach controller: configuration registers, input
// word register and result register. Depends on tac_pkg, tac_intf and tac_core.
//
//   channel   modport           carries
//   item_i    tac_in_if.sink    mode, seen, column, range_q8
//   result_o  tac_out_if.source status, yaw_q12, surge_q8
//   cfg_i     tac_cfg_if.sink   index, data (goal_range, centre_column)
//
// One word is taken every cycle while the result side is not stalled; its result passes
// from the input register through the single decision stage to the result register,
// and the counters update as a word leaves the input register.
// Reset clears the counters, the valid flags and loads the register defaults.
// A stalled result holds the result register, then the input register; input
// ready stays high while either stage has room.
module target_approach_controller_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  tac_in_if.sink    item_i,
  tac_out_if.source result_o,
  tac_cfg_if.sink   cfg_i
);

  logic [14:0] goal_range_q;
  logic [11:0] centre_column_q;

  logic             s1_valid_q;
  tac_pkg::item_t   s1_q;
  logic             out_valid_q;
  tac_pkg::result_t out_q;
  tac_pkg::result_t core_res;

  logic out_take;
  logic adv;
  logic in_acc;

  assign out_take     = !out_valid_q || result_o.ready;
  assign adv          = s1_valid_q && out_take;
  assign item_i.ready = !s1_valid_q || out_take;
  assign in_acc       = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_range_q    <= tac_pkg::GOAL_RANGE_RST;
      centre_column_q <= tac_pkg::CENTRE_COLUMN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tac_pkg::CFG_GOAL_RANGE:    goal_range_q    <= cfg_i.data[14:0];
        tac_pkg::CFG_CENTRE_COLUMN: centre_column_q <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= '{mode: item_i.mode, seen: item_i.seen, column: item_i.column,
                range_q8: item_i.range_q8};
    end
    if (adv) begin
      out_q <= core_res;
    end
  end

  tac_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .item_i          (s1_q),
    .goal_range_i    (goal_range_q),
    .centre_column_i (centre_column_q),
    .result_o        (core_res)
  );

  assign result_o.valid    = out_valid_q;
  assign result_o.status   = out_q.status;
  assign result_o.yaw_q12  = out_q.yaw_q12;
  assign result_o.surge_q8 = out_q.surge_q8;

`ifndef SYNTHESIS
  // A word in the input register stays there until the result register has room.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_take |=> s1_valid_q)
    else $error("input word dropped while the result register was stalled");

  // Only a running result carries a yaw command.
  a_yaw_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.yaw_q12 != '0) |-> out_q.status == tac_pkg::ST_RUNNING)
    else $error("yaw command on a result that is not running");

  // Surge stays within its saturation limit.
  a_surge_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.surge_q8 <= tac_pkg::SURGE_MAX)
    else $error("surge command above its limit");
`endif

endmodule

### dv/target_approach_controller_top_tb.sv
// Self-checking testbench for the target approach controller top level.
// Depends on tac_pkg, the tac_intf channel interfaces and the RTL of the block.
`timescale 1ns / 1ps

module target_approach_controller_top_tb;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [tac_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'hF;

  // Command shaping as plain integers for the predictor.
  localparam int DEADBAND   = 15;
  localparam int GAIN_NUM   = 14336;
  localparam int GAIN_DEN   = 1000;
  localparam int YAW_LIM    = 1229;
  localparam int TURN_LIM   = 60;
  localparam int BLIND_CMD  = 2048;
  localparam int SURGE_LO   = 512;
  localparam int SURGE_HI   = 5120;
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    tac_pkg::item_t   it;
    bit               fixed;
    tac_pkg::result_t want;
  } tick_t;

  logic clk_i;
  logic rst_ni;

  tac_in_if  item_if ();
  tac_out_if res_if ();
  tac_cfg_if cfg_if ();

  target_approach_controller_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // Predictor state and register copies.
  logic [14:0] goal_r   = 15'd256;
  logic [11:0] centre_r = 12'd320;
  logic [3:0]  lost_r   = '0;
  logic [2:0]  stable_r = '0;
  logic [8:0]  blind_r  = '0;

  tick_t            tick_q [$];
  tac_pkg::result_t cmd_q  [$];
  int               fault_count = 0;
  int               shown_count = 0;
  bit               calm = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 15);
  endfunction

  function automatic tac_pkg::result_t make_cmd(tac_pkg::status_e st, int yaw, int surge);
    tac_pkg::result_t r;
    r.status   = st;
    r.yaw_q12  = 12'(yaw);
    r.surge_q8 = 13'(surge);
    return r;
  endfunction

  // Advances the counter copies by one word and returns the command it causes.
  function automatic tac_pkg::result_t approach_step(tac_pkg::item_t it);
    int err;
    int mag;
    int rng;
    int yaw;
    int surge;
    int q;
    int derr;
    yaw   = 0;
    surge = 0;
    if (it.mode) begin
      lost_r   = '0;
      stable_r = '0;
      blind_r  = '0;
      return make_cmd(tac_pkg::ST_HALTED, 0, 0);
    end
    if (!it.seen) begin
      lost_r = lost_r + 4'd1;
      if (lost_r > tac_pkg::LOST_LIMIT) begin
        lost_r   = '0;
        stable_r = '0;
        blind_r  = '0;
        return make_cmd(tac_pkg::ST_FAILURE, 0, 0);
      end
      return make_cmd(tac_pkg::ST_RUNNING, 0, 0);
    end
    lost_r = '0;
    err = int'(centre_r) - int'(it.column);
    mag = (err < 0) ? -err : err;
    rng = int'($signed(it.range_q8));
    if (rng > 0 && rng < int'(goal_r)) begin
      if (stable_r < tac_pkg::STABLE_SAT) stable_r = stable_r + 3'd1;
      if (stable_r >= tac_pkg::STABLE_NEED) return make_cmd(tac_pkg::ST_SUCCESS, 0, 0);
    end else begin
      stable_r = '0;
    end
    if (mag >= DEADBAND) begin
      q = (mag * GAIN_NUM + GAIN_DEN / 2) / GAIN_DEN;
      if (q > YAW_LIM) q = YAW_LIM;
      yaw = (err > 0) ? -q : q;
    end
    if (rng <= 0) begin
      blind_r = blind_r + 9'd1;
      if (blind_r > tac_pkg::BLIND_LIMIT) begin
        blind_r  = '0;
        stable_r = '0;
        return make_cmd(tac_pkg::ST_FAILURE, 0, 0);
      end
      surge = (mag > TURN_LIM) ? 0 : BLIND_CMD;
    end else begin
      blind_r = '0;
      derr = rng - int'(goal_r);
      if (derr > 0 && mag <= TURN_LIM) begin
        surge = derr * 8;
        if (surge < SURGE_LO) surge = SURGE_LO;
        if (surge > SURGE_HI) surge = SURGE_HI;
      end
    end
    return make_cmd(tac_pkg::ST_RUNNING, yaw, surge);
  endfunction

  task automatic push_tick(bit mode, bit seen, int col, int rng, bit fixed = 1'b0,
                           tac_pkg::result_t want = '0);
    tick_t t;
    t.it.mode     = mode;
    t.it.seen     = seen;
    t.it.column   = 12'(col);
    t.it.range_q8 = 16'(rng);
    t.fixed       = fixed;
    t.want        = want;
    tick_q.push_back(t);
  endtask

  function automatic int near_centre();
    int c;
    c = int'(centre_r) + int'($urandom_range(0, 160)) - 80;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c;
  endfunction

  function automatic int unresolved_range();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return -32768;
      default: return -int'($urandom_range(0, 32768));
    endcase
  endfunction

  // Mostly approach runs toward the goal range, with losses, blind runs, halts and noise.
  task automatic gen_phase(int n, bit long_blind);
    int made;
    int len;
    int g;
    int rng;
    logic [31:0] w;
    made = 0;
    g = int'(goal_r);
    if (long_blind) begin
      for (int k = 0; k < 305; k++) push_tick(1'b0, 1'b1, near_centre(), unresolved_range());
      made = 305;
    end
    while (made < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          len = $urandom_range(8, 20);
          for (int k = 0; k < len; k++) begin
            if (k < len - 7 || g <= 1) rng = g + int'($urandom_range(1, 800));
            else rng = $urandom_range(1, g - 1);
            if (rng > 32767) rng = 32767;
            push_tick(1'b0, 1'b1, near_centre(), rng);
          end
        end
        8, 9, 10: begin
          len = $urandom_range(1, 11);
          for (int k = 0; k < len; k++) begin
            w = $urandom;
            push_tick(1'b0, 1'b0, int'(w[11:0]), int'($signed(w[31:16])));
          end
        end
        11, 12, 13: begin
          len = $urandom_range(1, 20);
          for (int k = 0; k < len; k++) push_tick(1'b0, 1'b1, near_centre(), unresolved_range());
        end
        14: begin
          w = $urandom;
          push_tick(1'b1, w[0], int'(w[12:1]), int'($signed(w[31:16])));
          len = 1;
        end
        default: begin
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++) begin
            w = $urandom;
            push_tick(w[31] & w[30], w[29], int'(w[11:0]), int'($signed({w[27:13], w[12]})));
          end
        end
      endcase
      made += len;
    end
  endtask

  task automatic drive_items();
    tick_t t;
    while (tick_q.size() > 0) begin
      @(negedge clk_i);
      if (roll_idle()) begin
        item_if.valid <= 1'b0;
      end else begin
        t = tick_q.pop_front();
        item_if.valid    <= 1'b1;
        item_if.mode     <= t.it.mode;
        item_if.seen     <= t.it.seen;
        item_if.column   <= t.it.column;
        item_if.range_q8 <= t.it.range_q8;
        @(posedge clk_i);
        while (!item_if.ready) @(posedge clk_i);
        if (t.fixed) begin
          void'(approach_step(t.it));
          cmd_q.push_back(t.want);
        end else begin
          cmd_q.push_back(approach_step(t.it));
        end
      end
    end
    @(negedge clk_i);
    item_if.valid <= 1'b0;
  endtask

  task automatic write_reg(logic [tac_pkg::CFG_IDX_W-1:0] idx,
                           logic [tac_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == tac_pkg::CFG_GOAL_RANGE) goal_r = data[14:0];
    else if (idx == tac_pkg::CFG_CENTRE_COLUMN) centre_r = data[11:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Every word gives one result, so an empty queue plus the pipeline depth means idle.
  task automatic settle();
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [15:0] goal_d, logic [15:0] centre_d, int n, bit quiet,
                           bit long_blind);
    settle();
    write_reg(tac_pkg::CFG_GOAL_RANGE, goal_d);
    write_reg(tac_pkg::CFG_CENTRE_COLUMN, centre_d);
    calm = quiet;
    gen_phase(n, long_blind);
    drive_items();
  endtask

  // Result side: random back-pressure.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    tac_pkg::result_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (cmd_q.size() == 0) begin
        fault_count++;
        if (shown_count < MAX_SHOWN) begin
          shown_count++;
          $display("unexpected result word: status %0d yaw %0d surge %0d",
                   res_if.status, $signed(res_if.yaw_q12), res_if.surge_q8);
        end
      end else begin
        e = cmd_q.pop_front();
        if (res_if.status !== e.status || res_if.yaw_q12 !== e.yaw_q12 ||
            res_if.surge_q8 !== e.surge_q8) begin
          fault_count++;
          if (shown_count < MAX_SHOWN) begin
            shown_count++;
            $display("mismatch (status/yaw/surge): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     e.status, $signed(e.yaw_q12), e.surge_q8,
                     res_if.status, $signed(res_if.yaw_q12), res_if.surge_q8);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    item_if.valid    = 1'b0;
    item_if.mode     = 1'b0;
    item_if.seen     = 1'b0;
    item_if.column   = '0;
    item_if.range_q8 = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset settings: goal 256, centre column 320.
    push_tick(1'b1, 1'b1, 4095, -1, 1'b1, make_cmd(tac_pkg::ST_HALTED, 0, 0));
    push_tick(1'b0, 1'b1, 320, 32767, 1'b1, make_cmd(tac_pkg::ST_RUNNING, 0, SURGE_HI));
    push_tick(1'b0, 1'b1, 0, -32768, 1'b1, make_cmd(tac_pkg::ST_RUNNING, -YAW_LIM, 0));
    push_tick(1'b0, 1'b1, 4095, 1);
    push_tick(1'b0, 1'b1, 320, 257);
    push_tick(1'b0, 1'b1, 305, 0);      // error right at the deadband edge
    push_tick(1'b0, 1'b1, 306, -1);     // error just inside the deadband
    push_tick(1'b0, 1'b1, 380, 0);      // last column that still surges
    push_tick(1'b0, 1'b1, 381, 0);
    push_tick(1'b0, 1'b1, 320, 256);    // range equal to the goal is not inside it
    for (int k = 0; k < 4; k++) push_tick(1'b0, 1'b1, 330, 255);
    push_tick(1'b0, 1'b1, 330, 255, 1'b1, make_cmd(tac_pkg::ST_SUCCESS, 0, 0));
    for (int k = 0; k < 8; k++)
      push_tick(1'b0, 1'b0, 4095, -1, 1'b1, make_cmd(tac_pkg::ST_RUNNING, 0, 0));
    push_tick(1'b0, 1'b0, 0, 0, 1'b1, make_cmd(tac_pkg::ST_FAILURE, 0, 0));
    drive_items();

    run_phase(16'd256, 16'd320, 400, 1'b0, 1'b1);
    run_phase(16'd1, 16'd0, 150, 1'b1, 1'b0);
    run_phase(16'h7FFF, 16'd4095, 150, 1'b0, 1'b0);
    // Bit 15 is dropped, which leaves a zero goal range.
    run_phase(16'h8000, 16'hF800, 150, 1'b0, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 150, 1'b0, 1'b0);
    settle();
    write_reg(CFG_SPARE, 16'($urandom));
    run_phase(16'($urandom_range(64, 2048)), 16'($urandom_range(0, 4095)), 150, 1'b0, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && cmd_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
